// ===== hw/rtl/rwsm_pkg.sv =====
// Shared types, constants and helpers of the raycast wall span merger.
package rwsm_pkg;

    // Fraction bits of the distance input
    localparam int DIST_FRAC_BITS = 8;
    // Dividend width: screen height shifted by the fraction bits
    localparam int NUM_W = 12 + DIST_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [14:0] H_MAX = 15'h7fff;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_OFFSET  = 2'd2;
    localparam logic [1:0] CFG_DEFTILE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROC,
        ST_DIV_S,
        ST_WAIT_S,
        ST_DIV_E,
        ST_WAIT_E,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [15:0] ray_len;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [14:0] height;
    } t_div_rsp;

    // floor(c * 9 / 10) for X-facing walls; /10 as multiply by 6554 >> 16
    function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic dim);
        logic [11:0] p;
        logic [23:0] m;
        p = 12'(c) * 12'd9;
        m = 24'(p) * 24'd6554;
        return dim ? m[23:16] : c;
    endfunction

endpackage

// ===== hw/rtl/rwsm_div.sv =====
// Iterative wall height unit: floor((H << frac) / dist), one quotient bit per cycle.
module rwsm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [11:0]       i_height,
    input  rwsm_pkg::t_div_req i_req,
    output rwsm_pkg::t_div_rsp o_rsp
);
    import rwsm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [15:0]       r_rem;
    logic [15:0]       r_den;
    logic [NUM_W-1:0]  r_quo;
    logic [14:0]       r_h;

    logic [16:0]       rem_sh;
    logic              fits;
    logic [15:0]       n_rem;
    logic [NUM_W-1:0]  n_quo;
    logic [21:0]       h_zero;
    logic [14:0]       h_zero_sat;
    logic [14:0]       h_div_sat;

    // One restoring step
    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        fits   = rem_sh >= {1'b0, r_den};
        n_rem  = fits ? 16'(rem_sh - {1'b0, r_den}) : rem_sh[15:0];
        n_quo  = {r_quo[NUM_W-2:0], fits};
    end

    // Distance zero stands for 0.001: h = 1000 * H, saturated
    always_comb begin
        h_zero     = (22'(i_height) << 10) - (22'(i_height) << 4) - (22'(i_height) << 3);
        h_zero_sat = (|h_zero[21:15]) ? H_MAX : h_zero[14:0];
        h_div_sat  = (|n_quo[NUM_W-1:15]) ? H_MAX : n_quo[14:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                if (i_req.ray_len == 16'd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(NUM_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_den <= i_req.ray_len;
            r_quo <= {i_height, {DIST_FRAC_BITS{1'b0}}};
            r_h   <= h_zero_sat;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_h   <= h_div_sat;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.height = r_h;

endmodule

// ===== hw/rtl/raycast_wall_span_merger_unit.sv =====
// Top level of the raycast wall span merger: column state, merge sequencer, quad output.
// Takes one screen column per beat and emits up to two wall quads per column. A column
// that emits nothing is only held if it is the first of a frame, else it frees the input
// after its merge step. Each quad costs two wall heights from the shared serial divider,
// which skips its loop for distance zero, plus sequencing (merge step and output beat)
// and however long the quad waits for i_ready. The input is not ready while a column is
// in work. The divider computes one quotient bit per cycle.
module raycast_wall_span_merger_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [13:0]        i_cfg_data,
    // column input
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_tile_id,
    input  logic [1:0]         i_wall_dir,
    input  logic [15:0]        i_distance,
    input  logic [7:0]         i_hit_cell_x,
    input  logic [7:0]         i_hit_cell_y,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    // quad output
    output logic               o_valid,
    input  logic               i_ready,
    output logic [11:0]        o_x_start,
    output logic [11:0]        o_x_end,
    output logic signed [15:0] o_start_top,
    output logic signed [15:0] o_start_bottom,
    output logic signed [15:0] o_end_top,
    output logic signed [15:0] o_end_bottom,
    output logic [7:0]         o_fill_red,
    output logic [7:0]         o_fill_green,
    output logic [7:0]         o_fill_blue,
    output logic               o_last_in_run
);
    import rwsm_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [12:0] r_width;
    logic [11:0] r_height;
    logic [13:0] r_offset;
    logic [7:0]  r_deftile;

    // frame state
    logic [11:0] r_col_cnt;
    logic [11:0] r_x;
    logic        r_is_last;
    logic        r_stage;

    // current and pending columns
    logic [7:0]  r_cur_tile, r_pend_tile;
    logic [1:0]  r_cur_dir, r_pend_dir;
    logic [15:0] r_cur_dist, r_pend_dist;
    logic [15:0] r_cur_cell, r_pend_cell;
    logic [23:0] r_cur_col, r_pend_col;

    // previous column and run start
    logic [7:0]  r_prev_tile;
    logic [1:0]  r_prev_dir;
    logic [15:0] r_prev_dist;
    logic [15:0] r_prev_cell;
    logic [23:0] r_prev_col;
    logic [7:0]  r_span_tile;
    logic [1:0]  r_span_dir;
    logic [15:0] r_span_dist;
    logic [11:0] r_span_x;

    // quad under construction
    logic [15:0] r_dist_s, r_dist_e;
    logic [14:0] r_hs;
    logic [11:0] r_q_xs, r_q_xe;
    logic [7:0]  r_q_r, r_q_g, r_q_b;
    logic        r_q_last;
    logic [15:0] r_st, r_sb, r_et, r_eb;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic        in_acc;
    logic        out_acc;
    logic [12:0] w_eff;
    logic        acc_last;

    // selected column for the merge step
    logic [7:0]  c_tile;
    logic [1:0]  c_dir;
    logic [15:0] c_dist;
    logic [15:0] c_cell;
    logic [23:0] c_col;
    logic [11:0] c_x;
    logic [7:0]  dx, dy;
    logic [8:0]  dsum;
    logic        jump, brk, absorb, emit;
    logic        more;
    logic [16:0] off17;
    logic [16:0] hs17, he17;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // clamp width to 1..4096 and find the last column
    always_comb begin
        if (r_width == 13'd0)
            w_eff = 13'd1;
        else if (r_width > 13'd4096)
            w_eff = 13'd4096;
        else
            w_eff = r_width;
        acc_last = {1'b0, r_col_cnt} >= (w_eff - 13'd1);
    end

    // merge decision for the held column (stage 0) or the last column (stage 1)
    always_comb begin
        c_tile = r_stage ? r_cur_tile : r_pend_tile;
        c_dir  = r_stage ? r_cur_dir  : r_pend_dir;
        c_dist = r_stage ? r_cur_dist : r_pend_dist;
        c_cell = r_stage ? r_cur_cell : r_pend_cell;
        c_col  = r_stage ? r_cur_col  : r_pend_col;
        c_x    = r_stage ? r_x : r_x - 12'd1;
        dx     = (c_cell[15:8] > r_prev_cell[15:8]) ? c_cell[15:8] - r_prev_cell[15:8]
                                                    : r_prev_cell[15:8] - c_cell[15:8];
        dy     = (c_cell[7:0] > r_prev_cell[7:0]) ? c_cell[7:0] - r_prev_cell[7:0]
                                                  : r_prev_cell[7:0] - c_cell[7:0];
        dsum   = {1'b0, dx} + {1'b0, dy};
        jump   = dsum > 9'd1;
        brk    = (c_tile != r_span_tile) || (c_dir != r_span_dir) || r_stage || jump;
        absorb = brk && (r_prev_tile == r_cur_tile) && (r_prev_dir == r_cur_dir)
                 && !r_stage && !jump;
        emit   = brk && !absorb;
        more   = !r_stage && r_is_last;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (r_col_cnt != 12'd0 || acc_last))
                    n_state = ST_PROC;
            end
            ST_PROC: begin
                if (emit)
                    n_state = ST_DIV_S;
                else if (more)
                    n_state = ST_PROC;
                else
                    n_state = ST_IDLE;
            end
            ST_DIV_S:  n_state = ST_WAIT_S;
            ST_WAIT_S: if (div_rsp.done) n_state = ST_DIV_E;
            ST_DIV_E:  n_state = ST_WAIT_E;
            ST_WAIT_E: if (div_rsp.done) n_state = ST_OUT;
            ST_OUT: begin
                if (out_acc)
                    n_state = more ? ST_PROC : ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // handshake and divider control
    always_comb begin
        o_ready         = 1'b0;
        o_valid         = 1'b0;
        div_req.start   = 1'b0;
        div_req.ray_len = r_dist_s;
        unique case (r_state)
            ST_IDLE:  o_ready = 1'b1;
            ST_DIV_S: div_req.start = 1'b1;
            ST_DIV_E: begin
                div_req.start   = 1'b1;
                div_req.ray_len = r_dist_e;
            end
            ST_OUT:   o_valid = 1'b1;
            default:  ;
        endcase
    end

    rwsm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_height (r_height),
        .i_req    (div_req),
        .o_rsp    (div_rsp)
    );

    // control registers and state that the reset defines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= 13'd640;
            r_height    <= 12'd480;
            r_offset    <= 14'd240;
            r_deftile   <= 8'd0;
            r_col_cnt   <= '0;
            r_stage     <= 1'b0;
            r_is_last   <= 1'b0;
            r_prev_tile <= 8'd0;
            r_prev_dir  <= '0;
            r_prev_dist <= '0;
            r_prev_cell <= '0;
            r_prev_col  <= '0;
            r_span_tile <= 8'd0;
            r_span_dir  <= '0;
            r_span_dist <= '0;
            r_span_x    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH:   r_width   <= i_cfg_data[12:0];
                    CFG_HEIGHT:  r_height  <= i_cfg_data[11:0];
                    CFG_OFFSET:  r_offset  <= i_cfg_data;
                    CFG_DEFTILE: r_deftile <= i_cfg_data[7:0];
                endcase
            end
            // column accept: frame start reload, count advance
            if (r_state == ST_IDLE && in_acc) begin
                r_is_last <= acc_last;
                r_stage   <= (r_col_cnt == 12'd0);
                r_col_cnt <= acc_last ? 12'd0 : r_col_cnt + 12'd1;
                if (r_col_cnt == 12'd0) begin
                    r_prev_tile <= r_deftile;
                    r_prev_dir  <= '0;
                    r_prev_dist <= '0;
                    r_prev_cell <= '0;
                    r_prev_col  <= '0;
                    r_span_tile <= r_deftile;
                    r_span_dir  <= '0;
                    r_span_dist <= '0;
                    r_span_x    <= '0;
                end
            end
            // merge step: an absorbed column keeps the previous column as is
            if (r_state == ST_PROC) begin
                if (!absorb) begin
                    r_prev_tile <= c_tile;
                    r_prev_dir  <= c_dir;
                    r_prev_dist <= c_dist;
                    r_prev_cell <= c_cell;
                    r_prev_col  <= c_col;
                end
                if (emit) begin
                    r_span_tile <= c_tile;
                    r_span_dir  <= c_dir;
                    r_span_dist <= c_dist;
                    r_span_x    <= c_x;
                end else if (more) begin
                    r_stage <= 1'b1;
                end
            end
            if (r_state == ST_OUT && out_acc && more)
                r_stage <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_x        <= r_col_cnt;
            r_cur_tile <= i_tile_id;
            r_cur_dir  <= i_wall_dir;
            r_cur_dist <= i_distance;
            r_cur_cell <= {i_hit_cell_x, i_hit_cell_y};
            r_cur_col  <= {i_red, i_green, i_blue};
            // first column of a frame that is not also its last is only held
            if (r_col_cnt == 12'd0 && !acc_last) begin
                r_pend_tile <= i_tile_id;
                r_pend_dir  <= i_wall_dir;
                r_pend_dist <= i_distance;
                r_pend_cell <= {i_hit_cell_x, i_hit_cell_y};
                r_pend_col  <= {i_red, i_green, i_blue};
            end
        end
        // hold the column for the next step once this step is done
        if ((r_state == ST_PROC && !emit && !more)
            || (r_state == ST_OUT && out_acc && !more)) begin
            r_pend_tile <= r_cur_tile;
            r_pend_dir  <= r_cur_dir;
            r_pend_dist <= r_cur_dist;
            r_pend_cell <= r_cur_cell;
            r_pend_col  <= r_cur_col;
        end
        // quad snapshot from run start and previous column
        if (r_state == ST_PROC && emit) begin
            r_dist_s <= r_span_dist;
            r_dist_e <= r_prev_dist;
            r_q_xs   <= r_span_x;
            r_q_xe   <= c_x;
            r_q_r    <= scale_chan(r_prev_col[23:16], r_prev_dir < 2'd2);
            r_q_g    <= scale_chan(r_prev_col[15:8], r_prev_dir < 2'd2);
            r_q_b    <= scale_chan(r_prev_col[7:0], r_prev_dir < 2'd2);
            r_q_last <= !more;
        end
        if (r_state == ST_WAIT_S && div_rsp.done)
            r_hs <= div_rsp.height;
        if (r_state == ST_WAIT_E && div_rsp.done) begin
            r_st <= 16'(off17 - hs17);
            r_sb <= 16'(off17 + hs17);
            r_et <= 16'(off17 - he17);
            r_eb <= 16'(off17 + he17);
        end
    end

    // top and bottom around the view offset
    always_comb begin
        off17 = {{3{r_offset[13]}}, r_offset};
        hs17  = {3'b000, r_hs[14:1]};
        he17  = {3'b000, div_rsp.height[14:1]};
    end

    assign o_x_start      = r_q_xs;
    assign o_x_end        = r_q_xe;
    assign o_start_top    = r_st;
    assign o_start_bottom = r_sb;
    assign o_end_top      = r_et;
    assign o_end_bottom   = r_eb;
    assign o_fill_red     = r_q_r;
    assign o_fill_green   = r_q_g;
    assign o_fill_blue    = r_q_b;
    assign o_last_in_run  = r_q_last;

endmodule

// ===== hw/rtl/rwsm_checker.sv =====
// Port-level checks of the wall span merger and their binding to the top level.
module rwsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [11:0] o_x_start,
    input logic [11:0] o_x_end,
    input logic        o_last_in_run
);

    // a stalled quad beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_x_start) && $stable(o_x_end))
        else $error("quad changed while stalled");

    // no quad right after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("quad valid after reset");

    // input is never taken while a quad waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("ready while a quad is pending");

    // a quad that is not the last of its column is followed by more work
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_in_run |=> !o_ready)
        else $error("column ended before its last quad");

    // a run never ends before it starts
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_x_start <= o_x_end)
        else $error("quad span reversed");

endmodule

bind raycast_wall_span_merger_unit rwsm_checker u_rwsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_x_start     (o_x_start),
    .o_x_end       (o_x_end),
    .o_last_in_run (o_last_in_run)
);
